@@ hw/rtl/hsp_pkg.sv @@
// Shared types, constants and functions for the Harley-Seal population counter.
// Holds the bit-plane vector type, the readout snapshot and the popcount and CSA helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hsp_pkg;

  localparam int unsigned VecBytes = 16;
  localparam int unsigned VecW     = 8 * VecBytes;
  localparam int unsigned HalfW    = VecW / 2;
  localparam int unsigned CountW   = 32;
  localparam int unsigned PcW      = $clog2(VecW + 1);
  localparam int unsigned WsumW    = PcW + 1;
  localparam int unsigned PosW     = 4;
  localparam int unsigned ByteCntW = 5;

  typedef logic [VecW-1:0]   vec_t;
  typedef logic [PcW-1:0]    pc_t;
  typedef logic [WsumW-1:0]  wsum_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [PosW-1:0]   pos_t;

  typedef struct packed {
    vec_t carry;
    vec_t sum;
  } csa_t;

  typedef struct packed {
    vec_t   ones;
    vec_t   twos;
    vec_t   fours;
    vec_t   eights;
    vec_t   pair;
    vec_t   carry2;
    vec_t   carry4;
    vec_t   carry8;
    vec_t   sixteens_vec;
    count_t sixteens_sum;
    count_t direct_sum;
  } snap_t;

  // Lane-parallel reduction: per-byte counts first, then byte sums folded into byte 0.
  function automatic pc_t popcnt(input vec_t v);
    vec_t x;
    x = v - ((v >> 1) & {VecBytes{8'h55}});
    x = (x & {VecBytes{8'h33}}) + ((x >> 2) & {VecBytes{8'h33}});
    x = (x + (x >> 4)) & {VecBytes{8'h0F}};
    x = x + (x >> 8);
    x = x + (x >> 16);
    x = x + (x >> 32);
    x = x + (x >> HalfW);
    return x[PcW-1:0];
  endfunction

  function automatic csa_t csa3(input vec_t a, input vec_t b, input vec_t c);
    csa_t r;
    vec_t u;
    u       = a ^ b;
    r.carry = (a & b) | (u & c);
    r.sum   = u ^ c;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hsp_csa_tree.sv @@
// Carry-save adder tree state: ones, twos, fours and eights planes, pending carries,
// block position and the sixteens and direct running totals.
// Depends on hsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsp_csa_tree (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire hsp_pkg::vec_t  vec_i,
  input  wire logic           full_i,
  input  wire logic           last_i,
  output hsp_pkg::snap_t      snap_o
);
  import hsp_pkg::*;

  vec_t   ones_q, ones_d, twos_q, twos_d, fours_q, fours_d, eights_q, eights_d;
  vec_t   pair_q, pair_d, carry2_q, carry2_d, carry4_q, carry4_d, carry8_q, carry8_d;
  vec_t   s16_q, s16_d;
  logic   s16_vld_q, s16_vld_d;
  pos_t   pos_q, pos_d;
  count_t sixteens_q, sixteens_d, direct_q, direct_d;
  csa_t   t2, f4, e8, s16;

  assign t2  = csa3(ones_q, pair_q, vec_i);
  assign f4  = csa3(twos_q, carry2_q, t2.carry);
  assign e8  = csa3(fours_q, carry4_q, f4.carry);
  assign s16 = csa3(eights_q, carry8_q, e8.carry);

  always_comb begin
    ones_d     = ones_q;
    twos_d     = twos_q;
    fours_d    = fours_q;
    eights_d   = eights_q;
    pair_d     = pair_q;
    carry2_d   = carry2_q;
    carry4_d   = carry4_q;
    carry8_d   = carry8_q;
    pos_d      = pos_q;
    s16_d      = '0;
    s16_vld_d  = 1'b0;
    sixteens_d = sixteens_q + (s16_vld_q ? count_t'(popcnt(s16_q)) : '0);
    direct_d   = direct_q + ((adv_i && !full_i) ? count_t'(popcnt(vec_i)) : '0);
    if (adv_i && full_i) begin
      pos_d = pos_q + pos_t'(1);
      if (!pos_q[0]) begin
        pair_d = vec_i;
      end else begin
        ones_d = t2.sum;
        pair_d = '0;
        if (!pos_q[1]) begin
          carry2_d = t2.carry;
        end else begin
          twos_d   = f4.sum;
          carry2_d = '0;
          if (!pos_q[2]) begin
            carry4_d = f4.carry;
          end else begin
            fours_d  = e8.sum;
            carry4_d = '0;
            if (!pos_q[3]) begin
              carry8_d = e8.carry;
            end else begin
              eights_d  = s16.sum;
              carry8_d  = '0;
              s16_d     = s16.carry;
              s16_vld_d = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    snap_o.ones         = ones_d;
    snap_o.twos         = twos_d;
    snap_o.fours        = fours_d;
    snap_o.eights       = eights_d;
    snap_o.pair         = pair_d;
    snap_o.carry2       = carry2_d;
    snap_o.carry4       = carry4_d;
    snap_o.carry8       = carry8_d;
    snap_o.sixteens_vec = s16_d;
    snap_o.sixteens_sum = sixteens_d;
    snap_o.direct_sum   = direct_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ones_q     <= '0;
      twos_q     <= '0;
      fours_q    <= '0;
      eights_q   <= '0;
      pair_q     <= '0;
      carry2_q   <= '0;
      carry4_q   <= '0;
      carry8_q   <= '0;
      s16_q      <= '0;
      s16_vld_q  <= 1'b0;
      pos_q      <= '0;
      sixteens_q <= '0;
      direct_q   <= '0;
    end else if (adv_i && last_i) begin
      ones_q     <= '0;
      twos_q     <= '0;
      fours_q    <= '0;
      eights_q   <= '0;
      pair_q     <= '0;
      carry2_q   <= '0;
      carry4_q   <= '0;
      carry8_q   <= '0;
      s16_q      <= '0;
      s16_vld_q  <= 1'b0;
      pos_q      <= '0;
      sixteens_q <= '0;
      direct_q   <= '0;
    end else begin
      ones_q     <= ones_d;
      twos_q     <= twos_d;
      fours_q    <= fours_d;
      eights_q   <= eights_d;
      pair_q     <= pair_d;
      carry2_q   <= carry2_d;
      carry4_q   <= carry4_d;
      carry8_q   <= carry8_d;
      s16_q      <= s16_d;
      s16_vld_q  <= s16_vld_d;
      pos_q      <= pos_d;
      sixteens_q <= sixteens_d;
      direct_q   <= direct_d;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/hsp_readout.sv @@
// Readout pipeline: snapshot register, plane popcount stage and result register.
// Forms 16*sixteens + 8*eights + 4*fours + 2*twos + ones + direct, modulo 2^32.
// Depends on hsp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hsp_readout (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire hsp_pkg::snap_t  snap_i,
  input  wire logic            snap_load_i,
  output logic                 snap_free_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output hsp_pkg::count_t      bit_count_o
);
  import hsp_pkg::*;

  snap_t  snap_q;
  logic   snap_vld_q, pc_vld_q, out_vld_q;
  logic   out_free, pc_free;
  wsum_t  w1_q, w2_q, w4_q, w8_q;
  count_t s_q, direct_q, result_q, result_d;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign pc_free     = !pc_vld_q || out_free;
  assign snap_free_o = !snap_vld_q || pc_free;

  assign result_d = (s_q << 4) + (count_t'(w8_q) << 3) + (count_t'(w4_q) << 2)
                  + (count_t'(w2_q) << 1) + count_t'(w1_q) + direct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= 1'b0;
      pc_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (snap_free_o) begin
        snap_vld_q <= snap_load_i;
      end
      if (pc_free) begin
        pc_vld_q <= snap_vld_q;
      end
      if (out_free) begin
        out_vld_q <= pc_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_free_o && snap_load_i) begin
      snap_q <= snap_i;
    end
    if (pc_free && snap_vld_q) begin
      w1_q     <= wsum_t'(popcnt(snap_q.ones)) + wsum_t'(popcnt(snap_q.pair));
      w2_q     <= wsum_t'(popcnt(snap_q.twos)) + wsum_t'(popcnt(snap_q.carry2));
      w4_q     <= wsum_t'(popcnt(snap_q.fours)) + wsum_t'(popcnt(snap_q.carry4));
      w8_q     <= wsum_t'(popcnt(snap_q.eights)) + wsum_t'(popcnt(snap_q.carry8));
      s_q      <= snap_q.sixteens_sum + count_t'(popcnt(snap_q.sixteens_vec));
      direct_q <= snap_q.direct_sum;
    end
    if (out_free && pc_vld_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign bit_count_o = result_q;

endmodule
`default_nettype wire

@@ hw/rtl/harley_seal_popcount.sv @@
// Top level of the Harley-Seal population counter: input register, CSA tree, readout.
// Depends on hsp_pkg, hsp_csa_tree and hsp_readout.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one 16-byte request per clock and keeps taking requests while up to three
// finished counts wait in the readout pipeline. Full vectors go through a carry-save adder
// tree; a partial vector has its valid low bytes counted directly. The count of a buffer
// passes the input register, the tree update into the snapshot register, the plane popcount
// register and then sits in the result register until taken. A new buffer may start in
// the cycle after the final request of the previous one.
module harley_seal_popcount (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] data_low_i,
  input  wire logic [63:0] data_high_i,
  input  wire logic [4:0]  valid_bytes_i,
  input  wire logic        last_vector_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      bit_count_o
);
  import hsp_pkg::*;

  vec_t  raw_vec, masked_vec, vec_q;
  logic  full_q, last_q, in_vld_q;
  logic  in_accept, adv, snap_free;
  snap_t snap;

  assign raw_vec = {data_high_i, data_low_i};

  always_comb begin
    for (int b = 0; b < VecBytes; b++) begin
      masked_vec[8*b +: 8] = (valid_bytes_i[ByteCntW-1] || (ByteCntW'(b) < valid_bytes_i))
                           ? raw_vec[8*b +: 8] : 8'h00;
    end
  end

  assign adv        = in_vld_q && (!last_q || snap_free);
  assign in_stall_o = in_vld_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      vec_q  <= masked_vec;
      full_q <= valid_bytes_i[ByteCntW-1];
      last_q <= last_vector_i;
    end
  end

  hsp_csa_tree u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vec_i  (vec_q),
    .full_i (full_q),
    .last_i (last_q),
    .snap_o (snap)
  );

  hsp_readout u_readout (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .snap_i      (snap),
    .snap_load_i (adv && last_q),
    .snap_free_o (snap_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .bit_count_o (bit_count_o)
  );

endmodule
`default_nettype wire

@@ hw/rtl/hsp_checker.sv @@
// Port-level checker for harley_seal_popcount and the bind that attaches it.
// Tracks final requests in flight against delivered counts. No package dependency.
`timescale 1ns / 1ps
`default_nettype none
module hsp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        last_vector_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] bit_count_o
);

  logic [2:0] pending_q, pending_d;
  logic       last_acc, out_acc;

  assign last_acc  = in_valid_i && !in_stall_o && last_vector_i;
  assign out_acc   = out_valid_o && !out_stall_i;
  assign pending_d = pending_q + 3'(last_acc) - 3'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result request dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(bit_count_o))
    else $error("Result count changed while stalled.");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("Result shown with no final request outstanding.");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("More final requests in flight than the pipeline holds.");

endmodule

bind harley_seal_popcount hsp_checker u_hsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .last_vector_i (last_vector_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .bit_count_o   (bit_count_o)
);
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the Harley-Seal population counter harley_seal_popcount.
// Holds a bit-plane predictor of the buffer count, a request driver, a result checker and
// the test sequence. Depends on hsp_pkg and the RTL of harley_seal_popcount.
`timescale 1ns / 1ps
module tb;
  import hsp_pkg::*;

  localparam int unsigned ItemTarget = 1350;
  localparam int unsigned IdleLimit  = 3000;
  localparam int unsigned MaxReports = 10;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [63:0] data_low_i    = '0;
  logic [63:0] data_high_i   = '0;
  logic [4:0]  valid_bytes_i = '0;
  logic        last_vector_i = 1'b0;
  logic        out_stall_i   = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [31:0] bit_count_o;

  vec_t   ones_bits, twos_bits, fours_bits, eights_bits;
  vec_t   pair_bits, carry2_bits, carry4_bits, carry8_bits;
  pos_t   block_pos;
  count_t sixteens_sum, direct_sum;

  count_t expected_counts[$];
  int     fault_count   = 0;
  int     sent_items    = 0;
  int     idle_cycles   = 0;
  bit     tx_idle_on    = 1'b1;
  bit     rx_idle_on    = 1'b1;
  int     rx_hold_len   = 0;

  harley_seal_popcount dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_low_i    (data_low_i),
    .data_high_i   (data_high_i),
    .valid_bytes_i (valid_bytes_i),
    .last_vector_i (last_vector_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .bit_count_o   (bit_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_planes();
    ones_bits    = '0;
    twos_bits    = '0;
    fours_bits   = '0;
    eights_bits  = '0;
    pair_bits    = '0;
    carry2_bits  = '0;
    carry4_bits  = '0;
    carry8_bits  = '0;
    block_pos    = '0;
    sixteens_sum = '0;
    direct_sum   = '0;
  endfunction

  function automatic void add3(input vec_t a, input vec_t b, input vec_t c,
                               output vec_t carry, output vec_t sum);
    carry = (a & b) | ((a ^ b) & c);
    sum   = a ^ b ^ c;
  endfunction

  function automatic void fold_vector(input vec_t v);
    vec_t c2, c4, c8, c16;
    if (!block_pos[0]) begin
      pair_bits = v;
    end else begin
      add3(ones_bits, pair_bits, v, c2, ones_bits);
      pair_bits = '0;
      if (!block_pos[1]) begin
        carry2_bits = c2;
      end else begin
        add3(twos_bits, carry2_bits, c2, c4, twos_bits);
        carry2_bits = '0;
        if (!block_pos[2]) begin
          carry4_bits = c4;
        end else begin
          add3(fours_bits, carry4_bits, c4, c8, fours_bits);
          carry4_bits = '0;
          if (!block_pos[3]) begin
            carry8_bits = c8;
          end else begin
            add3(eights_bits, carry8_bits, c8, c16, eights_bits);
            carry8_bits  = '0;
            sixteens_sum = sixteens_sum + count_t'($countones(c16));
          end
        end
      end
    end
    block_pos = block_pos + pos_t'(1);
  endfunction

  function automatic void tally_request(input logic [63:0] lo, input logic [63:0] hi,
                                        input logic [4:0] nb, input logic last);
    vec_t   v, mask;
    count_t total;
    v = {hi, lo};
    if (nb >= 5'd16) begin
      fold_vector(v);
    end else begin
      mask       = (vec_t'(1) << (8 * nb)) - vec_t'(1);
      direct_sum = direct_sum + count_t'($countones(v & mask));
    end
    if (last) begin
      total = sixteens_sum * 16
            + count_t'($countones(eights_bits)) * 8
            + count_t'($countones(fours_bits)) * 4
            + count_t'($countones(twos_bits)) * 2
            + count_t'($countones(ones_bits))
            + count_t'($countones(pair_bits))
            + count_t'($countones(carry2_bits)) * 2
            + count_t'($countones(carry4_bits)) * 4
            + count_t'($countones(carry8_bits)) * 8
            + direct_sum;
      expected_counts.push_back(total);
      clear_planes();
    end
  endfunction

  task automatic send_vec(input logic [63:0] lo, input logic [63:0] hi,
                          input logic [4:0] nb, input logic last);
    int gap;
    bit stalled;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_low_i    <= lo;
    data_high_i   <= hi;
    valid_bytes_i <= nb;
    last_vector_i <= last;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    tally_request(lo, hi, nb, last);
    sent_items++;
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'(1) << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [4:0] full_bytes();
    return ($urandom_range(0, 7) == 0) ? 5'($urandom_range(16, 31)) : 5'd16;
  endfunction

  task automatic send_buffer(input int n_full, input bit partial_tail, input bit noisy);
    int i;
    for (i = 0; i < n_full; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        send_vec(rand_word(), rand_word(), 5'($urandom_range(0, 15)), 1'b0);
      end
      send_vec(rand_word(), rand_word(), full_bytes(), (i == n_full - 1) && !partial_tail);
    end
    if (partial_tail) begin
      send_vec(rand_word(), rand_word(), 5'($urandom_range(0, 15)), 1'b1);
    end
  endtask

  task automatic test_extremes();
    send_vec('0, '0, 5'd16, 1'b1);
    send_vec('1, '1, 5'd16, 1'b1);
    send_vec('1, '1, 5'd0, 1'b1);
    send_vec('1, '1, 5'd1, 1'b0);
    send_vec('1, '1, 5'd8, 1'b0);
    send_vec('1, '1, 5'd9, 1'b0);
    send_vec('1, '1, 5'd15, 1'b1);
    send_vec({32{2'b10}}, {32{2'b10}}, 5'd17, 1'b0);
    send_vec({32{2'b01}}, {32{2'b01}}, 5'd31, 1'b1);
    send_vec('0, 64'h8000_0000_0000_0000, 5'd16, 1'b1);
    send_vec(64'h0000_0000_0000_0001, '0, 5'd16, 1'b0);
    send_vec('1, '1, 5'd7, 1'b0);
    send_vec('1, '1, 5'd24, 1'b0);
    send_vec('1, '1, 5'd0, 1'b0);
    send_vec('1, '1, 5'd16, 1'b1);
    send_vec('1, '1, 5'd15, 1'b0);
    send_vec('1, '1, 5'd16, 1'b1);
  endtask

  task automatic test_full_blocks();
    send_buffer(16, 1'b0, 1'b0);
    send_buffer(32, 1'b0, 1'b0);
    send_buffer(15, 1'b1, 1'b0);
    send_buffer(17, 1'b1, 1'b0);
    send_buffer(48, 1'b0, 1'b0);
  endtask

  task automatic test_random_buffers();
    int n;
    while (sent_items < ItemTarget - 260) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 40);
      send_buffer(n, $urandom_range(0, 2) == 0, 1'b1);
    end
  endtask

  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (sent_items < ItemTarget - 60) begin
      send_buffer($urandom_range(1, 20), $urandom_range(0, 1), 1'b1);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    rx_hold_len = 300;
    tx_idle_on  = 1'b0;
    while (sent_items < ItemTarget) begin
      send_buffer($urandom_range(1, 2), $urandom_range(0, 1), 1'b0);
    end
    tx_idle_on = 1'b1;
  endtask

  initial begin : receiver
    int  wait_n;
    bit  got;
    forever begin
      wait_n = rx_idle_on ? $urandom_range(0, 12) : 0;
      if (rx_hold_len > 0) begin
        wait_n      = rx_hold_len;
        rx_hold_len = 0;
      end
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        got = out_valid_o;
        @(posedge clk_i);
      end while (!got);
    end
  end

  always @(negedge clk_i) begin
    count_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_counts.size() == 0) begin
        if (fault_count < MaxReports) begin
          $display("Unexpected count %0d with no buffer outstanding", bit_count_o);
        end
        fault_count++;
      end else begin
        want = expected_counts.pop_front();
        if (bit_count_o !== want) begin
          if (fault_count < MaxReports) begin
            $display("Count mismatch: expected %0d, got %0d", want, bit_count_o);
          end
          fault_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clear_planes();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_full_blocks();
    test_random_buffers();
    test_back_to_back();
    test_backpressure();
    in_valid_i <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_counts.size() != 0) fault_count++;
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
